[sv/scheduled_gain_speed_regulator_core_macros.svh]
// assertion macros used by the checker file
`ifndef SCHEDULED_GAIN_SPEED_REGULATOR_CORE_MACROS_SVH
`define SCHEDULED_GAIN_SPEED_REGULATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define SGSR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, quiet during reset
`define SGSR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/sgsr_pkg.sv]
package sgsr_pkg;

   // item and storage sizes
   localparam int WHEELS     = 2;
   localparam int LEVEL_MAX  = 2047;
   localparam int LEVEL_W    = 11;
   localparam int LEVEL_MID  = 1024;
   localparam int DUTY_W     = 10;
   localparam int FRAC_BITS  = 20;
   localparam int SCALE_Q16  = 1311;

   // serial multiplier sizes
   localparam int MUL_A_W    = 27;
   localparam int MUL_B_W    = 18;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W  = 5;

   // serial divider sizes
   localparam int DIV_N_W    = 17;
   localparam int DIV_D_W    = 12;
   localparam int DIV_CNT_W  = 5;

   typedef struct packed {
      logic               wheel;
      logic signed [15:0] measured_speed;
      logic signed [11:0] set_speed;
   } req_type;

   typedef struct packed {
      logic                wheel_out;
      logic [DUTY_W-1:0]   duty;
      logic                direction;
      logic [LEVEL_W-1:0]  drive_level;
   } rsp_type;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN     = 3'd0,
      CSR_KI_LOW        = 3'd1,
      CSR_KI_HIGH       = 3'd2,
      CSR_GAIN_SPAN     = 3'd3,
      CSR_ERROR_LIMIT   = 3'd4,
      CSR_STEP_LIMIT    = 3'd5,
      CSR_STEP_DEADBAND = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_KP,
      ST_MUL_SCALE,
      ST_MUL_DIFF,
      ST_DIV,
      ST_MUL_KI,
      ST_ADJ,
      ST_LEVEL
   } state_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

endpackage

[sv/scheduled_gain_speed_regulator_core.sv]
// Wheel speed regulator with speed-scheduled integral gain.
// Input channel req_*: one transfer per control tick carries the wheel
// number, filtered speed (Q12.4) and target speed (integer mm/s).
// Result channel rsp_*: one transfer per input item with the wheel, duty,
// direction and the updated drive level of that wheel.
// Configuration channel csr_*: register index and data, always ready;
// write only while no item is in flight.
// One item is worked at a time, so the block takes no new item until the
// result of the last one is registered. The item passes through the
// bit-serial multiplier (four products) and the bit-serial divider, which
// form the gain and the step.
// A waiting result sits in the output register; the next item is accepted
// meanwhile and held in its final cycle until the result is taken.
// Reset clears the control state, loads the register defaults and sets
// each wheel's drive level to the stop midpoint 1024.
module scheduled_gain_speed_regulator_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sgsr_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sgsr_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [15:0]                csr_wdata
);

   // configuration registers
   logic [15:0] prop_gain_ff;
   logic [5:0]  ki_low_ff;
   logic [5:0]  ki_high_ff;
   logic [11:0] gain_span_ff;
   logic [11:0] error_limit_ff;
   logic [9:0]  step_limit_ff;
   logic [3:0]  step_deadband_ff;

   // control
   sgsr_pkg::state_type state_ff, state_in;
   logic                launched_ff, launched_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sgsr_pkg::rsp_type   rsp_ff, rsp_in;
   logic [sgsr_pkg::LEVEL_W-1:0] level_ff [sgsr_pkg::WHEELS];
   logic                level_we;
   logic [sgsr_pkg::LEVEL_W-1:0] level_new;

   // item working registers
   logic        wheel_ff, wheel_in;
   logic        err_neg_ff, err_neg_in;
   logic [16:0] err_mag_ff, err_mag_in;
   logic [11:0] mag_ff, mag_in;
   logic [32:0] pterm_ff, pterm_in;
   logic [26:0] smag_ff, smag_in;
   logic [16:0] dprod_ff, dprod_in;
   logic        ki_neg_ff, ki_neg_in;
   logic [17:0] ki_mag_ff, ki_mag_in;
   logic [44:0] kterm_ff, kterm_in;
   logic signed [30:0] adjc_ff, adjc_in;

   // combinational helpers
   logic signed [17:0] err_full;
   logic signed [17:0] err_negated;
   logic [16:0]        speed_abs;
   logic               diff_neg;
   logic [5:0]         diff_mag;
   logic [31:0]        lim_q20;
   logic signed [19:0] ki_full;
   logic signed [19:0] ki_negated;
   logic signed [46:0] term_p;
   logic signed [46:0] term_k;
   logic signed [46:0] adj_full;
   logic signed [46:0] slim;
   logic signed [30:0] adj_eff;
   logic [30:0]        adj_mag;
   logic [30:0]        dead_q20;
   logic signed [32:0] total;
   logic [sgsr_pkg::DUTY_W-1:0] duty_new;
   logic               dir_new;

   sgsr_pkg::mul_req_type             mul_req;
   logic                              mul_done;
   logic [sgsr_pkg::MUL_P_W-1:0]      mul_product;
   sgsr_pkg::div_req_type             div_req;
   logic                              div_done;
   logic [sgsr_pkg::DIV_N_W-1:0]      div_quotient;

   sgsr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .done    (mul_done),
      .product (mul_product)
   );

   sgsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_ready = (state_ff == sgsr_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= 16'd19661;
         ki_low_ff        <= 6'd6;
         ki_high_ff       <= 6'd12;
         gain_span_ff     <= 12'd1500;
         error_limit_ff   <= 12'd100;
         step_limit_ff    <= 10'd100;
         step_deadband_ff <= 4'd1;
      end else if (csr_valid) begin
         case (csr_index)
            sgsr_pkg::CSR_PROP_GAIN:     prop_gain_ff     <= csr_wdata;
            sgsr_pkg::CSR_KI_LOW:        ki_low_ff        <= csr_wdata[5:0];
            sgsr_pkg::CSR_KI_HIGH:       ki_high_ff       <= csr_wdata[5:0];
            sgsr_pkg::CSR_GAIN_SPAN:     gain_span_ff     <= csr_wdata[11:0];
            sgsr_pkg::CSR_ERROR_LIMIT:   error_limit_ff   <= csr_wdata[11:0];
            sgsr_pkg::CSR_STEP_LIMIT:    step_limit_ff    <= csr_wdata[9:0];
            sgsr_pkg::CSR_STEP_DEADBAND: step_deadband_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // input decode: error, speed magnitude and the scheduled integral gain
   always_comb begin
      err_full    = 18'(req_data.measured_speed)
                  - 18'($signed({req_data.set_speed, 4'b0000}));
      err_negated = -err_full;
      speed_abs   = req_data.measured_speed[15] ? (17'd0 - 17'(req_data.measured_speed))
                                                : 17'(req_data.measured_speed);
      diff_neg    = (ki_high_ff < ki_low_ff);
      diff_mag    = diff_neg ? (ki_low_ff - ki_high_ff) : (ki_high_ff - ki_low_ff);
      lim_q20     = {error_limit_ff, 20'd0};
      ki_full     = diff_neg ? (20'(ki_low_ff) - 20'(div_quotient))
                             : (20'(ki_low_ff) + 20'(div_quotient));
      ki_negated  = -ki_full;
   end

   // step assembly: proportional and integral terms, clamp to step limit
   always_comb begin
      term_p   = err_neg_ff ? $signed({14'd0, pterm_ff}) : -$signed({14'd0, pterm_ff});
      term_k   = (ki_neg_ff ^ err_neg_ff) ? -$signed({2'd0, kterm_ff})
                                          : $signed({2'd0, kterm_ff});
      adj_full = term_p + term_k;
      slim     = $signed({17'd0, step_limit_ff, 20'd0});
   end

   // level update: deadband, add, truncate toward zero, clamp, duty and direction
   always_comb begin
      adj_mag  = adjc_ff[30] ? 31'($unsigned(-adjc_ff)) : 31'($unsigned(adjc_ff));
      dead_q20 = {7'd0, step_deadband_ff, 20'd0};
      adj_eff  = (adj_mag < dead_q20) ? '0 : adjc_ff;
      total    = $signed({2'd0, level_ff[wheel_ff], 20'd0})
               + $signed({{2{adj_eff[30]}}, adj_eff});
      if (total[32]) begin
         level_new = '0;
      end else if (total[31:20] > 12'(sgsr_pkg::LEVEL_MAX)) begin
         level_new = sgsr_pkg::LEVEL_W'(sgsr_pkg::LEVEL_MAX);
      end else begin
         level_new = total[30:20];
      end
      if (level_new == sgsr_pkg::LEVEL_W'(sgsr_pkg::LEVEL_MID)
          || level_new == sgsr_pkg::LEVEL_W'(sgsr_pkg::LEVEL_MID - 1)) begin
         duty_new = '0;
         dir_new  = 1'b0;
      end else if (level_new < sgsr_pkg::LEVEL_W'(sgsr_pkg::LEVEL_MID - 1)) begin
         duty_new = sgsr_pkg::DUTY_W'(sgsr_pkg::LEVEL_W'(sgsr_pkg::LEVEL_MID - 1) - level_new);
         dir_new  = 1'b0;
      end else begin
         duty_new = sgsr_pkg::DUTY_W'(level_new - sgsr_pkg::LEVEL_W'(sgsr_pkg::LEVEL_MID));
         dir_new  = 1'b1;
      end
   end

   // sequencer: next state, unit launches, result capture
   always_comb begin
      state_in     = state_ff;
      launched_in  = launched_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      level_we     = 1'b0;
      wheel_in     = wheel_ff;
      err_neg_in   = err_neg_ff;
      err_mag_in   = err_mag_ff;
      mag_in       = mag_ff;
      pterm_in     = pterm_ff;
      smag_in      = smag_ff;
      dprod_in     = dprod_ff;
      ki_neg_in    = ki_neg_ff;
      ki_mag_in    = ki_mag_ff;
      kterm_in     = kterm_ff;
      adjc_in      = adjc_ff;
      mul_req.start    = 1'b0;
      mul_req.a        = '0;
      mul_req.b        = '0;
      div_req.start    = 1'b0;
      div_req.dividend = dprod_ff;
      div_req.divisor  = gain_span_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sgsr_pkg::ST_IDLE: begin
            if (req_valid) begin
               wheel_in   = req_data.wheel;
               err_neg_in = err_full[17];
               err_mag_in = err_full[17] ? err_negated[16:0] : err_full[16:0];
               mag_in     = speed_abs[15:4];
               state_in   = sgsr_pkg::ST_MUL_KP;
            end
         end
         sgsr_pkg::ST_MUL_KP: begin
            mul_req.a     = 27'(err_mag_ff);
            mul_req.b     = 18'(prop_gain_ff);
            mul_req.start = !launched_ff;
            launched_in   = 1'b1;
            if (mul_done) begin
               pterm_in    = mul_product[32:0];
               launched_in = 1'b0;
               state_in    = sgsr_pkg::ST_MUL_SCALE;
            end
         end
         sgsr_pkg::ST_MUL_SCALE: begin
            mul_req.a     = 27'(err_mag_ff);
            mul_req.b     = 18'(sgsr_pkg::SCALE_Q16);
            mul_req.start = !launched_ff;
            launched_in   = 1'b1;
            if (mul_done) begin
               // only the positive side of the scaled error is limited
               if (!err_neg_ff && ({5'd0, mul_product[26:0]} > lim_q20)) begin
                  smag_in = lim_q20[26:0];
               end else begin
                  smag_in = mul_product[26:0];
               end
               launched_in = 1'b0;
               state_in    = sgsr_pkg::ST_MUL_DIFF;
            end
         end
         sgsr_pkg::ST_MUL_DIFF: begin
            mul_req.a     = 27'(mag_ff);
            mul_req.b     = 18'(diff_mag);
            mul_req.start = !launched_ff;
            launched_in   = 1'b1;
            if (mul_done) begin
               dprod_in    = mul_product[16:0];
               launched_in = 1'b0;
               state_in    = sgsr_pkg::ST_DIV;
            end
         end
         sgsr_pkg::ST_DIV: begin
            div_req.start = !launched_ff;
            launched_in   = 1'b1;
            if (div_done) begin
               ki_neg_in   = ki_full[19];
               ki_mag_in   = ki_full[19] ? ki_negated[17:0] : ki_full[17:0];
               launched_in = 1'b0;
               state_in    = sgsr_pkg::ST_MUL_KI;
            end
         end
         sgsr_pkg::ST_MUL_KI: begin
            mul_req.a     = smag_ff;
            mul_req.b     = ki_mag_ff;
            mul_req.start = !launched_ff;
            launched_in   = 1'b1;
            if (mul_done) begin
               kterm_in    = mul_product;
               launched_in = 1'b0;
               state_in    = sgsr_pkg::ST_ADJ;
            end
         end
         sgsr_pkg::ST_ADJ: begin
            if (adj_full > slim) begin
               adjc_in = slim[30:0];
            end else if (adj_full < -slim) begin
               adjc_in = 31'(-slim);
            end else begin
               adjc_in = adj_full[30:0];
            end
            state_in = sgsr_pkg::ST_LEVEL;
         end
         sgsr_pkg::ST_LEVEL: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               level_we              = 1'b1;
               rsp_valid_in          = 1'b1;
               rsp_in.wheel_out      = wheel_ff;
               rsp_in.duty           = duty_new;
               rsp_in.direction      = dir_new;
               rsp_in.drive_level    = level_new;
               state_in              = sgsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in    = sgsr_pkg::ST_IDLE;
            launched_in = 1'b0;
         end
      endcase
   end

   // control registers and wheel levels
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sgsr_pkg::ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < sgsr_pkg::WHEELS; i++) begin
            level_ff[i] <= sgsr_pkg::LEVEL_W'(sgsr_pkg::LEVEL_MID);
         end
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
         if (level_we) begin
            level_ff[wheel_ff] <= level_new;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      wheel_ff   <= wheel_in;
      err_neg_ff <= err_neg_in;
      err_mag_ff <= err_mag_in;
      mag_ff     <= mag_in;
      pterm_ff   <= pterm_in;
      smag_ff    <= smag_in;
      dprod_ff   <= dprod_in;
      ki_neg_ff  <= ki_neg_in;
      ki_mag_ff  <= ki_mag_in;
      kterm_ff   <= kterm_in;
      adjc_ff    <= adjc_in;
   end

endmodule

[sv/sgsr_mul.sv]
module sgsr_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  sgsr_pkg::mul_req_type         mul_req,
   output logic                          done,
   output logic [sgsr_pkg::MUL_P_W-1:0]  product
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [sgsr_pkg::MUL_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [sgsr_pkg::MUL_A_W-1:0]    a_ff, a_in;
   logic [sgsr_pkg::MUL_P_W-1:0]    p_ff, p_in;
   logic [sgsr_pkg::MUL_A_W:0]      sum;

   // one multiplier bit per cycle: add, then shift the product right
   always_comb begin
      sum     = {1'b0, p_ff[sgsr_pkg::MUL_P_W-1:sgsr_pkg::MUL_B_W]}
              + {1'b0, (p_ff[0] ? a_ff : '0)};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      p_in    = p_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = mul_req.a;
         p_in    = {{sgsr_pkg::MUL_A_W{1'b0}}, mul_req.b};
      end else if (busy_ff) begin
         p_in   = {sum, p_ff[sgsr_pkg::MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sgsr_pkg::MUL_CNT_W'(sgsr_pkg::MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      p_ff <= p_in;
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

[sv/sgsr_div.sv]
module sgsr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  sgsr_pkg::div_req_type         div_req,
   output logic                          done,
   output logic [sgsr_pkg::DIV_N_W-1:0]  quotient
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [sgsr_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [sgsr_pkg::DIV_D_W-1:0]    d_ff, d_in;
   logic [sgsr_pkg::DIV_D_W-1:0]    rem_ff, rem_in;
   logic [sgsr_pkg::DIV_N_W-1:0]    q_ff, q_in;
   logic [sgsr_pkg::DIV_D_W:0]      trial;
   logic [sgsr_pkg::DIV_D_W:0]      trial_sub;
   logic                            fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial     = {rem_ff, q_ff[sgsr_pkg::DIV_N_W-1]};
      trial_sub = trial - {1'b0, d_ff};
      fits      = (trial >= {1'b0, d_ff});
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      d_in      = d_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = div_req.dividend;
         // a zero span behaves as one
         d_in    = (div_req.divisor == '0) ? sgsr_pkg::DIV_D_W'(1) : div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[sgsr_pkg::DIV_D_W-1:0] : trial[sgsr_pkg::DIV_D_W-1:0];
         q_in   = {q_ff[sgsr_pkg::DIV_N_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sgsr_pkg::DIV_CNT_W'(sgsr_pkg::DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

[sv/sgsr_checker.sv]
`include "scheduled_gain_speed_regulator_core_macros.svh"

module sgsr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sgsr_pkg::rsp_type rsp_data
);

   // a stalled result stays offered
   `SGSR_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // no result straight out of reset
   `SGSR_ASSERT_IMP(a_rsp_reset, $past(reset), !rsp_valid, "result valid right after reset")

   // one item at a time: an input transfer closes the input side
   `SGSR_ASSERT_NXT(a_req_busy, req_valid && req_ready, !req_ready, "input taken while busy")

   // forward direction only above the stop midpoint
   `SGSR_ASSERT_IMP(a_dir_level, rsp_valid && rsp_data.direction,
      rsp_data.drive_level[10] && (rsp_data.drive_level[9:0] != 10'd0),
      "forward direction with level at or below midpoint")

endmodule

bind scheduled_gain_speed_regulator_core sgsr_checker u_sgsr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[tb/sv/scheduled_gain_speed_regulator_core_tb.sv]
`timescale 1ns / 100ps

module scheduled_gain_speed_regulator_core_tb;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 250;

   // regulator settings and wheel levels as the predictor sees them
   class level_scoreboard;
      int unsigned kp, ki_lo, ki_hi, span, err_lim, step_lim, deadband;
      int unsigned level [sgsr_pkg::WHEELS];
      sgsr_pkg::rsp_type pending [$];
      int errors;

      function void clear();
         kp = 19661; ki_lo = 6; ki_hi = 12; span = 1500;
         err_lim = 100; step_lim = 100; deadband = 1;
         foreach (level[i]) level[i] = sgsr_pkg::LEVEL_MID;
         errors = 0;
      endfunction

      function void write_reg(sgsr_pkg::csr_index_type idx, logic [15:0] v);
         case (idx)
            sgsr_pkg::CSR_PROP_GAIN:     kp = 32'(v);
            sgsr_pkg::CSR_KI_LOW:        ki_lo = 32'(v[5:0]);
            sgsr_pkg::CSR_KI_HIGH:       ki_hi = 32'(v[5:0]);
            sgsr_pkg::CSR_GAIN_SPAN:     span = 32'(v[11:0]);
            sgsr_pkg::CSR_ERROR_LIMIT:   err_lim = 32'(v[11:0]);
            sgsr_pkg::CSR_STEP_LIMIT:    step_lim = 32'(v[9:0]);
            sgsr_pkg::CSR_STEP_DEADBAND: deadband = 32'(v[3:0]);
            default: ;
         endcase
      endfunction

      // work out the level update for one accepted request
      function void note_request(sgsr_pkg::req_type r);
         longint spd, tgt, err, mag, sp, ki, s, lim, adj, slim, amag, total, lvl;
         int w;
         sgsr_pkg::rsp_type o;
         w = int'(r.wheel) % sgsr_pkg::WHEELS;
         spd = longint'(r.measured_speed);
         tgt = longint'(r.set_speed);
         err = spd - tgt * 16;
         mag = (spd < 0 ? -spd : spd) / 16;
         sp = (span == 0) ? 1 : span;
         ki = longint'(ki_lo) + (mag * (longint'(ki_hi) - longint'(ki_lo))) / sp;
         s = err * sgsr_pkg::SCALE_Q16;
         lim = longint'(err_lim) <<< sgsr_pkg::FRAC_BITS;
         if (s > lim) s = lim;
         adj = -longint'(kp) * err + ki * s;
         slim = longint'(step_lim) <<< sgsr_pkg::FRAC_BITS;
         if (adj > slim) adj = slim;
         if (adj < -slim) adj = -slim;
         amag = adj < 0 ? -adj : adj;
         if (amag < (longint'(deadband) <<< sgsr_pkg::FRAC_BITS)) adj = 0;
         total = (longint'(level[w]) <<< sgsr_pkg::FRAC_BITS) + adj;
         if (total >= 0) lvl = total >>> sgsr_pkg::FRAC_BITS;
         else lvl = -((-total) >>> sgsr_pkg::FRAC_BITS);
         if (lvl < 0) lvl = 0;
         if (lvl > sgsr_pkg::LEVEL_MAX) lvl = sgsr_pkg::LEVEL_MAX;
         level[w] = 32'(lvl);
         o.wheel_out = w[0];
         o.drive_level = lvl[sgsr_pkg::LEVEL_W-1:0];
         if (lvl == sgsr_pkg::LEVEL_MID || lvl == sgsr_pkg::LEVEL_MID - 1) begin
            o.duty = '0; o.direction = 1'b0;
         end else if (lvl < sgsr_pkg::LEVEL_MID - 1) begin
            o.duty = sgsr_pkg::DUTY_W'(sgsr_pkg::LEVEL_MID - 1 - lvl);
            o.direction = 1'b0;
         end else begin
            o.duty = sgsr_pkg::DUTY_W'(lvl - sgsr_pkg::LEVEL_MID);
            o.direction = 1'b1;
         end
         pending.push_back(o);
      endfunction

      function void check_result(sgsr_pkg::rsp_type a);
         sgsr_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.wheel_out !== e.wheel_out) begin
            $display("%0t: wheel_out expected %0d actual %0d", $time, e.wheel_out, a.wheel_out);
            errors++;
         end
         if (a.duty !== e.duty) begin
            $display("%0t: duty expected %0d actual %0d", $time, e.duty, a.duty);
            errors++;
         end
         if (a.direction !== e.direction) begin
            $display("%0t: direction expected %0d actual %0d", $time, e.direction,
                     a.direction);
            errors++;
         end
         if (a.drive_level !== e.drive_level) begin
            $display("%0t: drive_level expected %0d actual %0d", $time, e.drive_level,
                     a.drive_level);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   sgsr_pkg::req_type req_data;
   sgsr_pkg::rsp_type rsp_data;
   logic [2:0] csr_index;
   logic [15:0] csr_wdata;
   level_scoreboard sb;
   int cycles;
   int stall_mode;

   scheduled_gain_speed_regulator_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // cycle counter and timeout
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // result transfers checked at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // receiver stall pattern, mode changes slowly
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (cycles % 7) < 3;
         endcase
         if ($urandom_range(0, 299) == 0) stall_mode <= int'($urandom_range(0, 3));
      end
   end

   task automatic write_csr(sgsr_pkg::csr_index_type idx, logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_request(sgsr_pkg::req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_one(logic w, logic signed [15:0] s, logic signed [11:0] t);
      sgsr_pkg::req_type r;
      r.wheel = w; r.measured_speed = s; r.set_speed = t;
      send_request(r);
      release_request();
   endtask

   function automatic sgsr_pkg::req_type random_request();
      sgsr_pkg::req_type r;
      r.wheel = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: begin
            r.measured_speed = 16'($urandom);
            r.set_speed = 12'($urandom);
         end
         default: begin
            // near the target, so the level walks rather than pins
            r.set_speed = $signed(12'($urandom_range(0, 4095)));
            r.measured_speed = 16'(int'(r.set_speed) * 16
                                   + $signed($urandom_range(0, 1599)) - 800);
         end
      endcase
      return r;
   endfunction

   task automatic random_phase(int n);
      int left, burst;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && left > 0) begin
            send_request(random_request());
            burst--; left--;
         end
         release_request();
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 300)) @(posedge clock);
      end
   endtask

   task automatic random_settings();
      write_csr(sgsr_pkg::CSR_PROP_GAIN, 16'($urandom));
      write_csr(sgsr_pkg::CSR_KI_LOW, 16'($urandom_range(0, 63)));
      write_csr(sgsr_pkg::CSR_KI_HIGH, 16'($urandom_range(0, 63)));
      write_csr(sgsr_pkg::CSR_GAIN_SPAN, 16'($urandom_range(0, 4095)));
      write_csr(sgsr_pkg::CSR_ERROR_LIMIT, 16'($urandom_range(0, 4095)));
      write_csr(sgsr_pkg::CSR_STEP_LIMIT, 16'($urandom_range(0, 1023)));
      write_csr(sgsr_pkg::CSR_STEP_DEADBAND, 16'($urandom_range(0, 15)));
   endtask

   initial begin
      sb = new();
      sb.clear();
      reset = 1'b1;
      req_valid = 1'b0; req_data = '0;
      csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: defaults, field extremes, both wheels
      send_one(1'b0, 16'sh7FFF, 12'sh800);
      send_one(1'b1, 16'sh8000, 12'sh7FF);
      send_one(1'b0, 16'sd0, 12'sd0);
      send_one(1'b1, 16'sd1600, 12'sd100);
      send_one(1'b0, -16'sd1600, -12'sd100);
      send_one(1'b1, 16'sd7, 12'sd0);
      send_one(1'b0, 16'hFFFF, 12'hFFF);
      for (int i = 0; i < 6; i++) send_one(1'b0, 16'sh7FFF, -12'sd2048);
      for (int i = 0; i < 6; i++) send_one(1'b1, 16'sh8000, 12'sd2047);
      wait_drained();

      // extreme settings: zero span and zero high gain, maximum for the rest
      write_csr(sgsr_pkg::CSR_PROP_GAIN, 16'hFFFF);
      write_csr(sgsr_pkg::CSR_KI_LOW, 16'd63);
      write_csr(sgsr_pkg::CSR_KI_HIGH, 16'd0);
      write_csr(sgsr_pkg::CSR_GAIN_SPAN, 16'd0);
      write_csr(sgsr_pkg::CSR_ERROR_LIMIT, 16'd4095);
      write_csr(sgsr_pkg::CSR_STEP_LIMIT, 16'd1023);
      write_csr(sgsr_pkg::CSR_STEP_DEADBAND, 16'd15);
      send_one(1'b0, 16'sh7FFF, 12'sh800);
      send_one(1'b1, 16'sh8000, 12'sh7FF);
      send_one(1'b0, 16'sd3, 12'sd0);
      send_one(1'b1, -16'sd30, 12'sd1);
      wait_drained();

      // minimum settings, but high gain at its maximum and a span of one
      write_csr(sgsr_pkg::CSR_PROP_GAIN, 16'd0);
      write_csr(sgsr_pkg::CSR_KI_LOW, 16'd0);
      write_csr(sgsr_pkg::CSR_KI_HIGH, 16'd63);
      write_csr(sgsr_pkg::CSR_GAIN_SPAN, 16'd1);
      write_csr(sgsr_pkg::CSR_ERROR_LIMIT, 16'd0);
      write_csr(sgsr_pkg::CSR_STEP_LIMIT, 16'd0);
      write_csr(sgsr_pkg::CSR_STEP_DEADBAND, 16'd0);
      send_one(1'b0, 16'sh7FFF, 12'sh800);
      send_one(1'b1, 16'sh8000, 12'sh7FF);
      wait_drained();

      // defaults back, random traffic
      write_csr(sgsr_pkg::CSR_PROP_GAIN, 16'd19661);
      write_csr(sgsr_pkg::CSR_KI_LOW, 16'd6);
      write_csr(sgsr_pkg::CSR_KI_HIGH, 16'd12);
      write_csr(sgsr_pkg::CSR_GAIN_SPAN, 16'd1500);
      write_csr(sgsr_pkg::CSR_ERROR_LIMIT, 16'd100);
      write_csr(sgsr_pkg::CSR_STEP_LIMIT, 16'd100);
      write_csr(sgsr_pkg::CSR_STEP_DEADBAND, 16'd1);
      random_phase(200);
      wait_drained();
      for (int p = 0; p < 5; p++) begin
         random_settings();
         random_phase(100);
         wait_drained();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
